>>> design/rte_pkg.sv
// Package for the rigid transform engine: word widths, mode codes,
// transfer payload types and lane/merge control structs. No dependencies.
`timescale 1ns / 1ps

package rte_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int LANES     = 3;
    localparam int COLS      = 4;

    localparam logic signed [WORD_W-1:0] ONE_WORD  = WORD_W'(1) <<< FRAC_BITS;
    localparam logic signed [WORD_W-1:0] WORD_MAX  = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN  = {1'b1, {(WORD_W-1){1'b0}}};

    localparam logic [1:0] MODE_WRITE     = 2'd0;
    localparam logic [1:0] MODE_TRANSFORM = 2'd1;
    localparam logic [1:0] MODE_INVERT    = 2'd2;
    localparam logic [1:0] MODE_READ      = 2'd3;

    localparam logic [1:0] ROW_FIXED = 2'd3;
    localparam logic [1:0] COL_TRANS = 2'd3;

    typedef struct packed {
        logic [1:0]               mode;
        logic [1:0]               row;
        logic [1:0]               col;
        logic signed [WORD_W-1:0] element_value;
        logic signed [WORD_W-1:0] point_x;
        logic signed [WORD_W-1:0] point_y;
        logic signed [WORD_W-1:0] point_z;
    } t_in_data;

    typedef struct packed {
        logic signed [WORD_W-1:0] out_x;
        logic signed [WORD_W-1:0] out_y;
        logic signed [WORD_W-1:0] out_z;
        logic signed [WORD_W-1:0] read_value;
        logic                     saturated;
    } t_out_data;

    typedef struct packed {
        logic start;
        logic neg;
        logic mul_en;
        logic acc_en;
    } t_lane_ctl;

    typedef struct packed {
        logic       fire;
        logic [1:0] mode;
    } t_merge_ctl;

endpackage

>>> design/rte_lane.sv
// One multiply-accumulate lane: registered product, wide accumulator,
// optional negate, shift by the fraction bits and saturate. Uses rte_pkg.
`timescale 1ns / 1ps

module rte_lane (
    input  logic                              i_clk,
    input  rte_pkg::t_lane_ctl                i_ctl,
    input  logic signed [rte_pkg::ACC_W-1:0]  i_init,
    input  logic signed [rte_pkg::WORD_W-1:0] i_a,
    input  logic signed [rte_pkg::WORD_W-1:0] i_b,
    output logic signed [rte_pkg::WORD_W-1:0] o_word,
    output logic                              o_sat
);

    logic signed [rte_pkg::PROD_W-1:0] r_prod;
    logic signed [rte_pkg::PROD_W-1:0] w_prod;
    logic signed [rte_pkg::ACC_W-1:0]  r_acc;
    logic                              r_neg;
    logic signed [rte_pkg::ACC_W-1:0]  w_signed;
    logic signed [rte_pkg::ACC_W-1:0]  w_shift;
    logic [rte_pkg::ACC_W-rte_pkg::WORD_W:0] w_top;

    assign w_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_ctl.start) begin
            r_acc <= i_init;
            r_neg <= i_ctl.neg;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + rte_pkg::ACC_W'(r_prod);
        end
    end

    always_comb begin
        w_signed = r_neg ? -r_acc : r_acc;
        w_shift  = w_signed >>> rte_pkg::FRAC_BITS;
        w_top    = w_shift[rte_pkg::ACC_W-1:rte_pkg::WORD_W-1];
        if ((&w_top) || !(|w_top)) begin
            o_word = w_shift[rte_pkg::WORD_W-1:0];
            o_sat  = 1'b0;
        end else begin
            o_word = w_signed[rte_pkg::ACC_W-1] ? rte_pkg::WORD_MIN : rte_pkg::WORD_MAX;
            o_sat  = 1'b1;
        end
    end

endmodule

>>> design/rte_merge.sv
// Merge stage: combines the three lane results (invert: saturation only)
// or the read word into one result and holds it in the output register. Uses rte_pkg.
`timescale 1ns / 1ps

module rte_merge (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  rte_pkg::t_merge_ctl                               i_ctl,
    input  logic [rte_pkg::LANES-1:0][rte_pkg::WORD_W-1:0]    i_lane_word,
    input  logic [rte_pkg::LANES-1:0]                         i_lane_sat,
    input  logic signed [rte_pkg::WORD_W-1:0]                 i_read_value,
    output logic                                              o_take_ok,
    output logic                                              o_out_valid,
    input  logic                                              i_out_ready,
    output rte_pkg::t_out_data                                o_out_data
);

    logic               r_valid;
    rte_pkg::t_out_data r_data;
    rte_pkg::t_out_data n_data;

    assign o_take_ok   = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_comb begin
        n_data = '0;
        unique case (i_ctl.mode)
            rte_pkg::MODE_TRANSFORM: begin
                n_data.out_x     = $signed(i_lane_word[0]);
                n_data.out_y     = $signed(i_lane_word[1]);
                n_data.out_z     = $signed(i_lane_word[2]);
                n_data.saturated = |i_lane_sat;
            end
            rte_pkg::MODE_INVERT: begin
                n_data.saturated = |i_lane_sat;
            end
            rte_pkg::MODE_READ: begin
                n_data.read_value = i_read_value;
            end
            rte_pkg::MODE_WRITE: begin
                n_data.saturated = 1'b0;
            end
            default: begin
                n_data = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.fire) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fire) begin
            r_data <= n_data;
        end
    end

endmodule

>>> design/rigid_transform_engine.sv
// Top level of the rigid transform engine: transform word store, sequencer,
// operand shift registers, three rte_lane instances and rte_merge. Uses rte_pkg.
//
//   channel  | signals                           | direction
//   input    | i_in_valid, o_in_ready, i_in_data | item in, one transfer per command
//   output   | o_out_valid, i_out_ready, o_out_data | one result transfer per item
//
// Transform and invert: load, three multiply steps in the lanes, one
// accumulate step, one result step. Write and read: load, one result step.
// An item is accepted only when idle. Reset loads identity rotation, zero
// translation. A result waits in the output register; a full register with
// the sink stalled holds the sequencer in its result step.
`timescale 1ns / 1ps

module rigid_transform_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rte_pkg::t_in_data   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rte_pkg::t_out_data  o_out_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;
    localparam logic [1:0] LAST_STEP = 2'(rte_pkg::LANES - 1);

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic [1:0] r_cnt;
    logic [1:0] r_mode;
    logic [1:0] r_row;
    logic [1:0] r_col;
    logic signed [rte_pkg::WORD_W-1:0] r_value;

    logic signed [rte_pkg::WORD_W-1:0] r_words [rte_pkg::LANES][rte_pkg::COLS];
    logic signed [rte_pkg::WORD_W-1:0] r_op    [rte_pkg::LANES][rte_pkg::LANES];
    logic signed [rte_pkg::WORD_W-1:0] r_vec   [rte_pkg::LANES];

    logic                                          w_in_fire;
    logic                                          w_take_ok;
    logic                                          w_fin_take;
    logic                                          w_arith;
    rte_pkg::t_lane_ctl                            w_lane_ctl;
    rte_pkg::t_merge_ctl                           w_merge_ctl;
    logic signed [rte_pkg::ACC_W-1:0]              w_init [rte_pkg::LANES];
    logic [rte_pkg::LANES-1:0][rte_pkg::WORD_W-1:0] w_lane_word;
    logic [rte_pkg::LANES-1:0]                     w_lane_sat;
    logic signed [rte_pkg::WORD_W-1:0]             w_read_value;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_arith    = (i_in_data.mode == rte_pkg::MODE_TRANSFORM) ||
                        (i_in_data.mode == rte_pkg::MODE_INVERT);
    assign w_fin_take = (r_state == ST_FIN) && w_take_ok;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_in_fire) n_state = w_arith ? ST_MAC : ST_FIN;
            ST_MAC:   if (r_cnt == LAST_STEP) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_FIN;
            ST_FIN:   if (w_take_ok) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_MAC) begin
                r_cnt <= r_cnt + 2'd1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_mode  <= i_in_data.mode;
            r_row   <= i_in_data.row;
            r_col   <= i_in_data.col;
            r_value <= i_in_data.element_value;
        end
    end

    // Load operands on accept; advance one column per MAC step.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            for (int i = 0; i < rte_pkg::LANES; i++) begin
                for (int j = 0; j < rte_pkg::LANES; j++) begin
                    r_op[i][j] <= (i_in_data.mode == rte_pkg::MODE_INVERT) ?
                                  r_words[j][i] : r_words[i][j];
                end
            end
            if (i_in_data.mode == rte_pkg::MODE_INVERT) begin
                for (int j = 0; j < rte_pkg::LANES; j++) begin
                    r_vec[j] <= r_words[j][rte_pkg::COLS-1];
                end
            end else begin
                r_vec[0] <= i_in_data.point_x;
                r_vec[1] <= i_in_data.point_y;
                r_vec[2] <= i_in_data.point_z;
            end
        end else if (r_state == ST_MAC) begin
            for (int i = 0; i < rte_pkg::LANES; i++) begin
                for (int j = 0; j < rte_pkg::LANES - 1; j++) begin
                    r_op[i][j] <= r_op[i][j+1];
                end
            end
            for (int j = 0; j < rte_pkg::LANES - 1; j++) begin
                r_vec[j] <= r_vec[j+1];
            end
        end
    end

    always_comb begin
        w_lane_ctl.start  = w_in_fire;
        w_lane_ctl.neg    = (i_in_data.mode == rte_pkg::MODE_INVERT);
        w_lane_ctl.mul_en = (r_state == ST_MAC);
        w_lane_ctl.acc_en = ((r_state == ST_MAC) && (r_cnt != 2'd0)) ||
                            (r_state == ST_DRAIN);
        for (int i = 0; i < rte_pkg::LANES; i++) begin
            w_init[i] = (i_in_data.mode == rte_pkg::MODE_TRANSFORM) ?
                        (rte_pkg::ACC_W'(r_words[i][rte_pkg::COLS-1]) <<< rte_pkg::FRAC_BITS) :
                        '0;
        end
    end

    for (genvar g = 0; g < rte_pkg::LANES; g++) begin : g_lane
        rte_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (w_lane_ctl),
            .i_init (w_init[g]),
            .i_a    (r_op[g][0]),
            .i_b    (r_vec[0]),
            .o_word (w_lane_word[g]),
            .o_sat  (w_lane_sat[g])
        );
    end

    always_comb begin
        if (r_row == rte_pkg::ROW_FIXED) begin
            w_read_value = (r_col == rte_pkg::COL_TRANS) ? rte_pkg::ONE_WORD : '0;
        end else begin
            w_read_value = r_words[r_row][r_col];
        end
    end

    assign w_merge_ctl.fire = w_fin_take;
    assign w_merge_ctl.mode = r_mode;

    rte_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_merge_ctl),
        .i_lane_word  (w_lane_word),
        .i_lane_sat   (w_lane_sat),
        .i_read_value (w_read_value),
        .o_take_ok    (w_take_ok),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

    // Store writes and the in-place inverse commit with the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rte_pkg::LANES; i++) begin
                for (int j = 0; j < rte_pkg::COLS; j++) begin
                    r_words[i][j] <= (i == j) ? rte_pkg::ONE_WORD : '0;
                end
            end
        end else if (w_fin_take) begin
            if (r_mode == rte_pkg::MODE_WRITE) begin
                if (r_row != rte_pkg::ROW_FIXED) begin
                    r_words[r_row][r_col] <= r_value;
                end
            end else if (r_mode == rte_pkg::MODE_INVERT) begin
                for (int i = 0; i < rte_pkg::LANES; i++) begin
                    for (int j = 0; j < rte_pkg::LANES; j++) begin
                        r_words[i][j] <= r_words[j][i];
                    end
                    r_words[i][rte_pkg::COLS-1] <= $signed(w_lane_word[i]);
                end
            end
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> !o_in_ready)
        else $error("accepted a transfer while busy");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) && !w_take_ok |=> (r_state == ST_FIN))
        else $error("result step left with output register full");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> (r_cnt <= LAST_STEP))
        else $error("MAC step counter out of range");

    a_invert_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin_take && (r_mode == rte_pkg::MODE_INVERT) |=>
        (r_words[1][1] == $past(r_words[1][1])))
        else $error("inverse changed a diagonal element");

    a_out_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin_take |=> o_out_valid)
        else $error("result lost at output register");

endmodule

>>> bench/tb_rigid_transform_engine.sv
// Self-checking testbench for rigid_transform_engine: a scoreboard class that predicts
// each result from its own copy of the transform, plus drivers with random idle cycles.
// Depends on rte_pkg and rigid_transform_engine.
`timescale 1ns / 1ps

class transform_scoreboard;
    localparam int SUM_W = 2 * rte_pkg::WORD_W + 4;
    typedef logic signed [SUM_W-1:0]           wide_t;
    typedef logic signed [rte_pkg::WORD_W-1:0] word_t;

    word_t              pose_words[12];
    rte_pkg::t_out_data expected_results[$];
    int                 errors;
    int                 checked;
    int                 writes;
    int                 transforms;
    int                 inverts;
    int                 reads;
    int                 clipped_results;

    function new();
        errors          = 0;
        checked         = 0;
        writes          = 0;
        transforms      = 0;
        inverts         = 0;
        reads           = 0;
        clipped_results = 0;
        foreach (pose_words[k]) pose_words[k] = '0;
        pose_words[0]  = rte_pkg::ONE_WORD;
        pose_words[5]  = rte_pkg::ONE_WORD;
        pose_words[10] = rte_pkg::ONE_WORD;
    endfunction

    function wide_t mul_wide(word_t a, word_t b);
        wide_t wa;
        wide_t wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    function word_t shift_clip(wide_t sum, inout bit clipped);
        wide_t shifted;
        wide_t hi;
        wide_t lo;
        hi      = rte_pkg::WORD_MAX;
        lo      = rte_pkg::WORD_MIN;
        shifted = sum >>> rte_pkg::FRAC_BITS;
        if (shifted > hi) begin
            clipped = 1'b1;
            return rte_pkg::WORD_MAX;
        end
        if (shifted < lo) begin
            clipped = 1'b1;
            return rte_pkg::WORD_MIN;
        end
        return shifted[rte_pkg::WORD_W-1:0];
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    function void note_command(rte_pkg::t_in_data cmd);
        rte_pkg::t_out_data want;
        word_t              pt[3];
        word_t              mapped[3];
        word_t              new_t[3];
        word_t              swap;
        wide_t              sum;
        bit                 clipped;
        want    = '0;
        clipped = 1'b0;
        pt[0]   = cmd.point_x;
        pt[1]   = cmd.point_y;
        pt[2]   = cmd.point_z;
        case (cmd.mode)
            rte_pkg::MODE_WRITE: begin
                writes++;
                if (cmd.row != rte_pkg::ROW_FIXED)
                    pose_words[cmd.row * 4 + cmd.col] = cmd.element_value;
            end
            rte_pkg::MODE_TRANSFORM: begin
                transforms++;
                for (int i = 0; i < 3; i++) begin
                    sum = mul_wide(pose_words[i * 4 + 3], rte_pkg::ONE_WORD);
                    for (int j = 0; j < 3; j++)
                        sum += mul_wide(pose_words[i * 4 + j], pt[j]);
                    mapped[i] = shift_clip(sum, clipped);
                end
                want.out_x = mapped[0];
                want.out_y = mapped[1];
                want.out_z = mapped[2];
            end
            rte_pkg::MODE_INVERT: begin
                inverts++;
                for (int i = 0; i < 3; i++) begin
                    sum = '0;
                    for (int j = 0; j < 3; j++)
                        sum += mul_wide(pose_words[j * 4 + i], pose_words[j * 4 + 3]);
                    new_t[i] = shift_clip(-sum, clipped);
                end
                for (int i = 0; i < 3; i++) begin
                    for (int j = i + 1; j < 3; j++) begin
                        swap                  = pose_words[i * 4 + j];
                        pose_words[i * 4 + j] = pose_words[j * 4 + i];
                        pose_words[j * 4 + i] = swap;
                    end
                end
                for (int i = 0; i < 3; i++) pose_words[i * 4 + 3] = new_t[i];
            end
            default: begin
                reads++;
                if (cmd.row == rte_pkg::ROW_FIXED)
                    want.read_value = (cmd.col == rte_pkg::COL_TRANS) ? rte_pkg::ONE_WORD : '0;
                else
                    want.read_value = pose_words[cmd.row * 4 + cmd.col];
            end
        endcase
        want.saturated = clipped;
        if (clipped) clipped_results++;
        expected_results.push_back(want);
    endfunction

    task report(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task compare_field(string name, logic signed [31:0] got, logic signed [31:0] want);
        if (got !== want)
            report($sformatf("result %0d %s: got %0d (0x%08h), want %0d (0x%08h)",
                             checked, name, got, got, want, want));
    endtask

    task check_result(rte_pkg::t_out_data got);
        rte_pkg::t_out_data want;
        if (expected_results.size() == 0) begin
            report($sformatf("unexpected result x=%0d y=%0d z=%0d read=%0d sat=%0b",
                             got.out_x, got.out_y, got.out_z, got.read_value, got.saturated));
            return;
        end
        want = expected_results.pop_front();
        compare_field("out_x", got.out_x, want.out_x);
        compare_field("out_y", got.out_y, want.out_y);
        compare_field("out_z", got.out_z, want.out_z);
        compare_field("read_value", got.read_value, want.read_value);
        compare_field("saturated", 32'(got.saturated), 32'(want.saturated));
        checked++;
    endtask
endclass

module tb_rigid_transform_engine;
    import rte_pkg::*;

    localparam int ITEM_TARGET  = 1150;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int Q_ONE        = 1 << FRAC_BITS;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_data   i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_data  o_out_data;

    transform_scoreboard sb;
    int                  items_sent    = 0;
    int                  results_taken = 0;
    bit                  tx_burst      = 1'b0;
    bit                  rx_burst      = 1'b0;

    rigid_transform_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic issue(logic [1:0] mode, logic [1:0] row, logic [1:0] col,
                         logic signed [31:0] value, logic signed [31:0] x,
                         logic signed [31:0] y, logic signed [31:0] z);
        t_in_data cmd;
        int       gap;
        cmd.mode          = mode;
        cmd.row           = row;
        cmd.col           = col;
        cmd.element_value = value;
        cmd.point_x       = x;
        cmd.point_y       = y;
        cmd.point_z       = z;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= cmd;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_command(cmd);
        items_sent++;
    endtask

    function automatic logic signed [31:0] pick_value(bit full_range);
        case ($urandom_range(0, 15))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return $urandom;
            3:       return 0;
            4:       return Q_ONE;
            5:       return -Q_ONE;
            default: return full_range ? $signed($urandom)
                                       : $signed($urandom_range(0, 8 * Q_ONE)) - 4 * Q_ONE;
        endcase
    endfunction

    task automatic random_command();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            for (int k = 0; k < 12; k++)
                issue(MODE_WRITE, 2'(k / 4), 2'(k % 4), pick_value(1'b0),
                      $urandom, $urandom, $urandom);
        end else if (pick < 40) begin
            issue(MODE_WRITE, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  pick_value($urandom_range(0, 3) == 0), $urandom, $urandom, $urandom);
        end else if (pick < 70) begin
            issue(MODE_TRANSFORM, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  $urandom, pick_value(1'b1), pick_value(1'b1), pick_value(1'b1));
        end else if (pick < 80) begin
            issue(MODE_INVERT, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  $urandom, $urandom, $urandom, $urandom);
        end else begin
            issue(MODE_READ, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin : stimulus
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(MODE_READ, ROW_FIXED, COL_TRANS, 0, 0, 0, 0);
        issue(MODE_READ, ROW_FIXED, 2'd1, 0, 0, 0, 0);
        issue(MODE_WRITE, ROW_FIXED, 2'd0, WORD_MAX, 0, 0, 0);
        issue(MODE_READ, 2'd0, 2'd0, 0, 0, 0, 0);
        issue(MODE_TRANSFORM, 2'd0, 2'd0, 0, WORD_MAX, WORD_MIN, 0);
        issue(MODE_TRANSFORM, 2'd0, 2'd0, 0, Q_ONE + Q_ONE / 2, -(2 * Q_ONE + Q_ONE / 4),
              3 * Q_ONE);
        issue(MODE_WRITE, 2'd0, COL_TRANS, WORD_MAX, 0, 0, 0);
        issue(MODE_TRANSFORM, 2'd0, 2'd0, 0, WORD_MAX, 0, 0);
        issue(MODE_WRITE, 2'd1, COL_TRANS, WORD_MIN, 0, 0, 0);
        issue(MODE_TRANSFORM, 2'd0, 2'd0, 0, 0, WORD_MIN, 0);
        issue(MODE_INVERT, 2'd0, 2'd0, 0, 0, 0, 0);
        issue(MODE_READ, 2'd1, COL_TRANS, 0, 0, 0, 0);
        issue(MODE_READ, 2'd0, COL_TRANS, 0, 0, 0, 0);
        issue(MODE_WRITE, 2'd0, 2'd1, Q_ONE / 2, 0, 0, 0);
        issue(MODE_WRITE, 2'd2, 2'd0, -(3 * Q_ONE / 4), 0, 0, 0);
        issue(MODE_INVERT, 2'd0, 2'd0, 0, 0, 0, 0);
        issue(MODE_READ, 2'd1, 2'd0, 0, 0, 0, 0);
        issue(MODE_READ, 2'd0, 2'd2, 0, 0, 0, 0);
        issue(MODE_WRITE, 2'd0, 2'd0, WORD_MIN, 0, 0, 0);
        issue(MODE_WRITE, 2'd2, 2'd2, WORD_MAX, 0, 0, 0);
        issue(MODE_TRANSFORM, 2'd0, 2'd0, 0, WORD_MIN, WORD_MIN, WORD_MIN);
        issue(MODE_INVERT, 2'd0, 2'd0, 0, 0, 0, 0);
        issue(MODE_READ, 2'd2, COL_TRANS, 0, 0, 0, 0);
        issue(MODE_READ, 2'd0, 2'd0, 0, 0, 0, 0);

        while (items_sent < ITEM_TARGET) begin
            random_command();
            if ($urandom_range(0, 59) == 0) tx_burst = !tx_burst;
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d commands: %0d writes, %0d transforms, %0d inverts, %0d reads.",
                 items_sent, sb.writes, sb.transforms, sb.inverts, sb.reads);
        $display("Checked %0d results, %0d of them with saturation; %0d mismatches.",
                 sb.checked, sb.clipped_results, sb.errors);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : result_sink
        int  gap;
        bit  hold_done;
        hold_done = 1'b0;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (results_taken == HOLD_AT && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            gap = rx_burst ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            sb.check_result(o_out_data);
            results_taken++;
            if ($urandom_range(0, 59) == 0) rx_burst = !rx_burst;
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> rigid_transform_engine.f
design/rte_pkg.sv
design/rte_lane.sv
design/rte_merge.sv
design/rigid_transform_engine.sv
bench/tb_rigid_transform_engine.sv
